// File: src/hsvr_pkg.sv
// ----------------------------------------------------------------------------
// hsvr_pkg
// Shared types, constants and 8-bit scaling functions for the rainbow
// HSV to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsvr_pkg;

   // Hue sector position scaling constants
   localparam int unsigned THIRD_MULT     = 256 / 3;
   localparam int unsigned TWOTHIRD_MULT  = (256 * 2) / 3;
   localparam logic [7:0]  FULL_LEVEL     = 8'd255;
   localparam logic [7:0]  ZERO_LEVEL     = 8'd0;

   // Input item
   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] saturation;
      logic [7:0] brightness;
   } req_type;

   // Result item
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   // Stage 1 -> stage 2: raw rainbow color plus precomputed scale factors
   typedef struct packed {
      rsp_type    color;
      logic       sat_full;
      logic       sat_zero;
      logic [7:0] desat;
      logic       val_full;
      logic [7:0] val_sq;
   } hue_out_type;

   // Stage 2 -> stage 3: desaturated color plus brightness factor
   typedef struct packed {
      rsp_type    color;
      logic       val_full;
      logic [7:0] val_sq;
   } sat_out_type;

   // (a*b) >> 8
   function automatic logic [7:0] scale8(input logic [7:0] a, input logic [7:0] b);
      logic [15:0] prod;
      prod = 16'(a) * 16'(b);
      return prod[15:8];
   endfunction

   // (a*b) >> 8, plus one when both operands are nonzero
   function automatic logic [7:0] scale8_video(input logic [7:0] a,
                                               input logic [7:0] b);
      logic [7:0] base;
      logic       bump;
      base = scale8(a, b);
      bump = (a != ZERO_LEVEL) && (b != ZERO_LEVEL);
      return base + {7'd0, bump};
   endfunction

endpackage

`default_nettype wire

// File: src/hsvr_hue_stage.sv
// ----------------------------------------------------------------------------
// hsvr_hue_stage
// First pipeline stage: maps hue onto the rainbow sectors and squares the
// saturation complement and the brightness for the later stages.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvr_hue_stage
   import hsvr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        enable,
   input  wire logic        in_valid,
   input  wire req_type     in_data,
   output      logic        out_valid,
   output      hue_out_type out_data
);

   logic        valid_ff;
   hue_out_type data_ff;
   hue_out_type data_in;

   logic [7:0] pos8;
   logic [7:0] third;
   logic [7:0] twothirds;
   logic [7:0] sat_inv;
   logic [2:0] sector;

   // Rainbow sector map with yellow boost
   always_comb begin
      pos8      = {in_data.hue[4:0], 3'b000};
      third     = scale8(pos8, 8'(THIRD_MULT));
      twothirds = scale8(pos8, 8'(TWOTHIRD_MULT));
      sector    = in_data.hue[7:5];
      sat_inv   = FULL_LEVEL - in_data.saturation;

      data_in = '0;
      unique case (sector)
         3'd0: begin
            data_in.color = '{red: FULL_LEVEL - third, green: third, blue: ZERO_LEVEL};
         end
         3'd1: begin
            data_in.color = '{red: 8'd171, green: 8'd85 + third, blue: ZERO_LEVEL};
         end
         3'd2: begin
            data_in.color = '{red: 8'd171 - twothirds, green: 8'd170 + third,
                              blue: ZERO_LEVEL};
         end
         3'd3: begin
            data_in.color = '{red: ZERO_LEVEL, green: FULL_LEVEL - third, blue: third};
         end
         3'd4: begin
            data_in.color = '{red: ZERO_LEVEL, green: 8'd171 - twothirds,
                              blue: 8'd85 + twothirds};
         end
         3'd5: begin
            data_in.color = '{red: third, green: ZERO_LEVEL, blue: FULL_LEVEL - third};
         end
         3'd6: begin
            data_in.color = '{red: 8'd85 + third, green: ZERO_LEVEL, blue: 8'd171 - third};
         end
         default: begin
            data_in.color = '{red: 8'd170 + third, green: ZERO_LEVEL, blue: 8'd85 - third};
         end
      endcase

      // Scale factors for the later stages
      data_in.sat_full = (in_data.saturation == FULL_LEVEL);
      data_in.sat_zero = (in_data.saturation == ZERO_LEVEL);
      data_in.desat    = scale8_video(sat_inv, sat_inv);
      data_in.val_full = (in_data.brightness == FULL_LEVEL);
      data_in.val_sq   = scale8_video(in_data.brightness, in_data.brightness);
   end

   // Stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// File: src/hsvr_sat_stage.sv
// ----------------------------------------------------------------------------
// hsvr_sat_stage
// Second pipeline stage: pulls the color toward the saturation floor.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvr_sat_stage
   import hsvr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        enable,
   input  wire logic        in_valid,
   input  wire hue_out_type in_data,
   output      logic        out_valid,
   output      sat_out_type out_data
);

   logic        valid_ff;
   sat_out_type data_ff;
   sat_out_type data_in;
   logic [7:0]  keep;

   // Desaturation: full keeps color, zero gives white
   always_comb begin
      keep             = FULL_LEVEL - in_data.desat;
      data_in.val_full = in_data.val_full;
      data_in.val_sq   = in_data.val_sq;
      priority if (in_data.sat_full) begin
         data_in.color = in_data.color;
      end else if (in_data.sat_zero) begin
         data_in.color = '{red: FULL_LEVEL, green: FULL_LEVEL, blue: FULL_LEVEL};
      end else begin
         data_in.color.red   = scale8(in_data.color.red, keep) + in_data.desat;
         data_in.color.green = scale8(in_data.color.green, keep) + in_data.desat;
         data_in.color.blue  = scale8(in_data.color.blue, keep) + in_data.desat;
      end
   end

   // Stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// File: src/hsvr_val_stage.sv
// ----------------------------------------------------------------------------
// hsvr_val_stage
// Third pipeline stage: scales all channels by the squared brightness and
// holds the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvr_val_stage
   import hsvr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        enable,
   input  wire logic        in_valid,
   input  wire sat_out_type in_data,
   output      logic        out_valid,
   output      rsp_type     out_data
);

   logic    valid_ff;
   rsp_type data_ff;
   rsp_type data_in;

   // Brightness scaling: full passes, zero square gives black
   always_comb begin
      priority if (in_data.val_full) begin
         data_in = in_data.color;
      end else if (in_data.val_sq == ZERO_LEVEL) begin
         data_in = '{red: ZERO_LEVEL, green: ZERO_LEVEL, blue: ZERO_LEVEL};
      end else begin
         data_in.red   = scale8(in_data.color.red, in_data.val_sq);
         data_in.green = scale8(in_data.color.green, in_data.val_sq);
         data_in.blue  = scale8(in_data.color.blue, in_data.val_sq);
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// File: src/hsv_rainbow_to_rgb_top.sv
// Items pass the hue map, saturation and brightness registers in order. One
// item per cycle while no result is stalled; three register stages (hue map,
// saturation, brightness), each with one set of 8x8 multipliers.
// The whole pipeline holds while the result waits under rsp_stall.
// Reset: synchronous, active high; clears the stage valid bits only.
// ----------------------------------------------------------------------------
// hsv_rainbow_to_rgb_top
// Rainbow HSV to RGB converter for LED pixel streams.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_rainbow_to_rgb_top
   import hsvr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_stall,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_stall,
   output      rsp_type rsp_data
);

   logic        advance;
   logic        hue_valid;
   hue_out_type hue_data;
   logic        sat_valid;
   sat_out_type sat_data;

   // Pipeline moves unless a finished item is held at the output
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   hsvr_hue_stage u_hue (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (hue_valid),
      .out_data  (hue_data)
   );

   hsvr_sat_stage u_sat (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (hue_valid),
      .in_data   (hue_data),
      .out_valid (sat_valid),
      .out_data  (sat_data)
   );

   hsvr_val_stage u_val (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (sat_valid),
      .in_data   (sat_data),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: src/hsvr_checker.sv
// ----------------------------------------------------------------------------
// hsvr_checker
// Port-level checks for the rainbow HSV to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvr_checker
   import hsvr_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // A held result stays valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result item dropped while stalled");

   // Input side is held back only by a stalled result
   assert property (@(posedge clock)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without output backpressure");

   // Empty pipeline after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Zero saturation at full brightness comes out white when the output does not stall
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.saturation == ZERO_LEVEL
       && req_data.brightness == FULL_LEVEL) ##1 !rsp_stall ##1 !rsp_stall
      |=> rsp_valid && rsp_data.red == FULL_LEVEL && rsp_data.green == FULL_LEVEL
          && rsp_data.blue == FULL_LEVEL)
      else $error("white item not delivered after three cycles");

endmodule

bind hsv_rainbow_to_rgb_top hsvr_checker u_hsvr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rainbow HSV to RGB converter. A table of
// directed pixels runs first, then random pixels under three idle patterns.
// Each accepted pixel's color is taken from the table or predicted locally, and
// each result is compared field by field, in order.
// ----------------------------------------------------------------------------

module tb_top
   import hsvr_pkg::*;
;

   // Run sizing
   localparam int unsigned DIRECTED_ROWS   = 25;
   localparam int unsigned ITEMS_PER_PHASE = 617;
   localparam int unsigned CYCLE_LIMIT     = 250000;
   localparam int unsigned LONG_HOLD       = 80;
   localparam int unsigned DRAIN_CYCLES    = 8;

   // Rainbow hue sectors, top three hue bits
   typedef enum logic [2:0] {
      SEC_RED    = 3'd0,
      SEC_ORANGE = 3'd1,
      SEC_YELLOW = 3'd2,
      SEC_GREEN  = 3'd3,
      SEC_AQUA   = 3'd4,
      SEC_BLUE   = 3'd5,
      SEC_PURPLE = 3'd6,
      SEC_PINK   = 3'd7
   } hue_sector_type;

   // One row of directed stimulus; rgb only used when typed is set
   typedef struct packed {
      req_type    px;
      logic       typed;
      rsp_type    rgb;
   } stim_row_type;

   localparam stim_row_type DIRECTED_TABLE [0:DIRECTED_ROWS-1] = '{
      // sector starts at full saturation and brightness
      {8'd0,   8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0  },
      {8'd32,  8'd255, 8'd255, 1'b1, 8'd171, 8'd85,  8'd0  },
      {8'd64,  8'd255, 8'd255, 1'b1, 8'd171, 8'd170, 8'd0  },
      {8'd96,  8'd255, 8'd255, 1'b1, 8'd0,   8'd255, 8'd0  },
      {8'd128, 8'd255, 8'd255, 1'b1, 8'd0,   8'd171, 8'd85 },
      {8'd160, 8'd255, 8'd255, 1'b1, 8'd0,   8'd0,   8'd255},
      {8'd192, 8'd255, 8'd255, 1'b1, 8'd85,  8'd0,   8'd171},
      {8'd224, 8'd255, 8'd255, 1'b1, 8'd170, 8'd0,   8'd85 },
      // zero saturation gives white
      {8'd0,   8'd0,   8'd255, 1'b1, 8'd255, 8'd255, 8'd255},
      {8'd200, 8'd0,   8'd255, 1'b1, 8'd255, 8'd255, 8'd255},
      // zero brightness gives black
      {8'd0,   8'd255, 8'd0,   1'b1, 8'd0,   8'd0,   8'd0  },
      {8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0  },
      // sector ends
      {8'd31,  8'd255, 8'd255, 1'b0, 24'd0},
      {8'd63,  8'd255, 8'd255, 1'b0, 24'd0},
      {8'd95,  8'd255, 8'd255, 1'b0, 24'd0},
      {8'd127, 8'd255, 8'd255, 1'b0, 24'd0},
      {8'd159, 8'd255, 8'd255, 1'b0, 24'd0},
      {8'd191, 8'd255, 8'd255, 1'b0, 24'd0},
      {8'd223, 8'd255, 8'd255, 1'b0, 24'd0},
      {8'd255, 8'd255, 8'd255, 1'b0, 24'd0},
      // near-white, near-full, brightness that squares to one
      {8'd0,   8'd1,   8'd255, 1'b0, 24'd0},
      {8'd100, 8'd254, 8'd254, 1'b0, 24'd0},
      {8'd40,  8'd128, 8'd1,   1'b0, 24'd0},
      // alternating bit patterns
      {8'hAA,  8'h55,  8'h55,  1'b0, 24'd0},
      {8'h55,  8'hAA,  8'hAA,  1'b0, 24'd0}
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   rsp_type     rgb_expected [$];
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   logic        hold_request = 1'b0;
   int unsigned items_sent = 0;
   int unsigned results_seen = 0;
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;

   hsv_rainbow_to_rgb_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // (a*b) >> 8
   function automatic logic [7:0] mul_hi8(input logic [7:0] a, input logic [7:0] b);
      logic [15:0] prod;
      prod = {8'd0, a} * {8'd0, b};
      return prod[15:8];
   endfunction

   // same, rounded up by one when both factors are nonzero
   function automatic logic [7:0] mul_hi8_video(input logic [7:0] a,
                                                input logic [7:0] b);
      logic [7:0] base;
      base = mul_hi8(a, b);
      if (a != 8'd0 && b != 8'd0) base = base + 8'd1;
      return base;
   endfunction

   // Expected color for one pixel: hue map, then desaturate, then dim
   function automatic rsp_type rainbow_rgb(input req_type px);
      logic [7:0] pos8;
      logic [7:0] third;
      logic [7:0] twothird;
      logic [7:0] desat;
      logic [7:0] keep;
      logic [7:0] v2;
      rsp_type    c;
      pos8     = {px.hue[4:0], 3'b000};
      third    = mul_hi8(pos8, 8'd85);
      twothird = mul_hi8(pos8, 8'd170);
      c        = '0;
      unique case (hue_sector_type'(px.hue[7:5]))
         SEC_RED: begin
            c.red = 8'd255 - third;     c.green = third;
         end
         SEC_ORANGE: begin
            c.red = 8'd171;             c.green = 8'd85 + third;
         end
         SEC_YELLOW: begin
            c.red = 8'd171 - twothird;  c.green = 8'd170 + third;
         end
         SEC_GREEN: begin
            c.green = 8'd255 - third;   c.blue = third;
         end
         SEC_AQUA: begin
            c.green = 8'd171 - twothird; c.blue = 8'd85 + twothird;
         end
         SEC_BLUE: begin
            c.red = third;              c.blue = 8'd255 - third;
         end
         SEC_PURPLE: begin
            c.red = 8'd85 + third;      c.blue = 8'd171 - third;
         end
         default: begin
            c.red = 8'd170 + third;     c.blue = 8'd85 - third;
         end
      endcase

      // saturation stage, skipped at full saturation
      if (px.saturation != 8'd255) begin
         if (px.saturation == 8'd0) begin
            c.red = 8'd255; c.green = 8'd255; c.blue = 8'd255;
         end else begin
            desat   = mul_hi8_video(8'd255 - px.saturation, 8'd255 - px.saturation);
            keep    = 8'd255 - desat;
            c.red   = mul_hi8(c.red, keep) + desat;
            c.green = mul_hi8(c.green, keep) + desat;
            c.blue  = mul_hi8(c.blue, keep) + desat;
         end
      end

      // brightness stage, skipped at full brightness
      if (px.brightness != 8'd255) begin
         v2 = mul_hi8_video(px.brightness, px.brightness);
         if (v2 == 8'd0) begin
            c = '0;
         end else begin
            c.red   = mul_hi8(c.red, v2);
            c.green = mul_hi8(c.green, v2);
            c.blue  = mul_hi8(c.blue, v2);
         end
      end
      return c;
   endfunction

   // Random pixel, biased toward extremes and sector edges now and then
   function automatic req_type random_pixel();
      req_type px;
      px = req_type'(24'($urandom));
      case ($urandom_range(9))
         6: px.saturation = ($urandom_range(1) != 0) ? 8'd0 : 8'd255;
         7: px.brightness = ($urandom_range(1) != 0) ? 8'd0 : 8'd255;
         8: px.hue[4:0]   = ($urandom_range(1) != 0) ? 5'h00 : 5'h1F;
         9: begin
            px.saturation = 8'd255;
            px.brightness = 8'd255;
         end
         default: ;
      endcase
      return px;
   endfunction

   // Offer one pixel, hold it until accepted, then log what must come back
   task automatic send_pixel(input req_type px, input rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (req_stall);
      rgb_expected.push_back(want);
      items_sent++;
   endtask

   // Sender pauses until every pending color has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (rgb_expected.size() != 0) @(posedge clock);
   endtask

   // Receiver: random stall, or a long hold-off once one is requested
   initial begin
      int unsigned hold_left;
      logic        hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // Result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (rgb_expected.size() == 0) begin
            $error("result with nothing pending: %h", rsp_data);
            fail_count++;
         end else begin
            want = rgb_expected.pop_front();
            if (rsp_data.red != want.red) begin
               $error("red: expected %0d, got %0d", want.red, rsp_data.red);
               fail_count++;
            end
            if (rsp_data.green != want.green) begin
               $error("green: expected %0d, got %0d", want.green, rsp_data.green);
               fail_count++;
            end
            if (rsp_data.blue != want.blue) begin
               $error("blue: expected %0d, got %0d", want.blue, rsp_data.blue);
               fail_count++;
            end
         end
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("run exceeded %0d cycles", CYCLE_LIMIT);
      $display("FAILURE");
      $finish;
   end

   // Main sequence
   initial begin
      stim_row_type row;
      req_type      px;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table under the first idle pattern
      send_idle_pct = 7;
      recv_idle_pct = 76;
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = DIRECTED_TABLE[i];
         send_pixel(row.px, row.typed ? row.rgb : rainbow_rgb(row.px));
      end

      // random pixels, three idle patterns
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 7;
               recv_idle_pct = 76;
            end
            1: begin
               wait_drained();
               send_idle_pct = 76;
               recv_idle_pct = 7;
            end
            default: begin
               wait_drained();
               send_idle_pct = 0;
               recv_idle_pct = 0;
               // receiver holds off while the sender keeps pushing
               hold_request = 1'b1;
            end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            px = random_pixel();
            send_pixel(px, rainbow_rgb(px));
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d pixels in (%0d from the table), %0d colors checked",
               items_sent, DIRECTED_ROWS, results_seen);
      $display("idle patterns: slow receiver, slow sender, none; %0d failures",
               fail_count);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
